// File: rtl/sitda_pkg.sv
`default_nettype none

package sitda_pkg;

    // ASCII codes used by the character stage
    localparam logic [6:0] ASCII_ZERO  = 7'h30;
    localparam logic [6:0] ASCII_NINE  = 7'h39;
    localparam logic [6:0] ASCII_MINUS = 7'h2D;

    // Entries in the queue between the front and the back part
    localparam int QUEUE_DEPTH = 2;

    // Map a BCD digit to its ASCII character
    function automatic logic [6:0] digit_to_ascii(input logic [3:0] digit);
        digit_to_ascii = ASCII_ZERO + {3'b000, digit};
    endfunction

endpackage

`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii.sv
`default_nettype none

// Channel  | Direction | Ports                         | Payload
// ---------+-----------+-------------------------------+----------------------------------
// s_       | in        | s_valid, s_ready, s_value     | signed integer, VALUE_BITS bits
// m_       | out       | m_valid, m_ready, m_character | ASCII '-' or '0'..'9', last flag
//          |           | m_last                        |
//
// The back part loads each item, converts it by shift-add-3 one magnitude bit at a time,
// then skips suppressed leading zeros, leaves the zero skip and emits the characters.
// Suppressed zeros plus digits fill ten digit slots at 32 bits. The back part takes no
// new item until the current one is done. The front part and a two-entry queue accept
// up to three more items.
// Reset (aresetn low at a clock edge) empties the front stage, the queue and the
// output register and returns the converter to idle.
// A stalled m_ready holds the current character and pauses emission; s_ready drops
// only once the front stage and the queue are full.

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [VALUE_BITS-1:0] s_value,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic             [6:0]            m_character,
    output logic                              m_last
);

    localparam int ENTRY_BITS = VALUE_BITS + 1;

    // Front to queue: sign flag and magnitude of one item
    logic                  f_valid;
    logic                  f_ready;
    logic                  f_neg;
    logic [VALUE_BITS-1:0] f_mag;

    // Queue to back
    logic                  q_valid;
    logic                  q_ready;
    logic [ENTRY_BITS-1:0] q_data;

    // Accept an item, split off the sign and form the magnitude
    sitda_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_neg   (f_neg),
        .f_mag   (f_mag)
    );

    // Hold classified items while the converter is busy
    sitda_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_neg, f_mag}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // Convert to BCD one bit a cycle, drop leading zeros, emit characters
    sitda_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_neg       (q_data[ENTRY_BITS-1]),
        .q_mag       (q_data[VALUE_BITS-1:0]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

`default_nettype wire

// File: rtl/sitda_front.sv
`default_nettype none

module sitda_front #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [VALUE_BITS-1:0] s_value,
    output logic                              f_valid,
    input  wire logic                         f_ready,
    output logic                              f_neg,
    output logic             [VALUE_BITS-1:0] f_mag
);

    logic                  f_valid_reg;
    logic                  f_valid_next;
    logic                  f_neg_reg;
    logic [VALUE_BITS-1:0] f_mag_reg;
    logic [VALUE_BITS-1:0] raw_bits;
    logic [VALUE_BITS-1:0] neg_bits;
    logic                  take;

    assign s_ready  = !f_valid_reg || f_ready;
    assign take     = s_valid && s_ready;
    assign raw_bits = VALUE_BITS'(s_value);
    // Two's complement in an unsigned word: the most negative value maps to 2^(N-1)
    assign neg_bits = (~raw_bits) + {{(VALUE_BITS-1){1'b0}}, 1'b1};

    always_comb begin
        f_valid_next = f_valid_reg;
        if (take) begin
            f_valid_next = 1'b1;
        end else if (f_ready) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f_neg_reg <= raw_bits[VALUE_BITS-1];
            f_mag_reg <= raw_bits[VALUE_BITS-1] ? neg_bits : raw_bits;
        end
    end

    assign f_valid = f_valid_reg;
    assign f_neg   = f_neg_reg;
    assign f_mag   = f_mag_reg;

endmodule

`default_nettype wire

// File: rtl/sitda_queue.sv
`default_nettype none

module sitda_queue #(
    parameter int WIDTH = 33
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);

    localparam int DEPTH    = sitda_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                push;
    logic                pop;

    assign in_ready  = (cnt_reg != CNT_BITS'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_BITS'(DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

// File: rtl/sitda_back.sv
`default_nettype none

module sitda_back #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire logic                  q_neg,
    input  wire logic [VALUE_BITS-1:0] q_mag,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [6:0]            m_character,
    output logic                       m_last
);

    localparam int NUM_DIGITS = (3 * VALUE_BITS) / 10 + 1;
    localparam int BCD_BITS   = 4 * NUM_DIGITS;
    localparam int BIT_BITS   = $clog2(VALUE_BITS);
    localparam int DIG_BITS   = $clog2(NUM_DIGITS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CONV   = 3'd1;
    localparam logic [2:0] ST_SKIP   = 3'd2;
    localparam logic [2:0] ST_SIGN   = 3'd3;
    localparam logic [2:0] ST_DIGITS = 3'd4;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic [BCD_BITS-1:0]   bcd_reg;
    logic [BCD_BITS-1:0]   bcd_next;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic [BIT_BITS-1:0]   bit_cnt_reg;
    logic [BIT_BITS-1:0]   bit_cnt_next;
    logic [DIG_BITS-1:0]   dig_cnt_reg;
    logic [DIG_BITS-1:0]   dig_cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [6:0]            out_char_reg;
    logic [6:0]            out_char_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic [3:0]            top_digit;
    logic                  load;

    assign q_ready   = (state_reg == ST_IDLE);
    assign load      = !out_valid_reg || m_ready;
    assign top_digit = bcd_reg[BCD_BITS-1 -: 4];

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                bcd_reg[4*d +: 4] + 4'd3 : bcd_reg[4*d +: 4];
        end
    end

    always_comb begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    neg_next     = q_neg;
                    mag_next     = q_mag;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_BITS'(VALUE_BITS - 1);
                    dig_cnt_next = DIG_BITS'(NUM_DIGITS - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = {bcd_adj[BCD_BITS-2:0], mag_reg[VALUE_BITS-1]};
                mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                if (bit_cnt_reg == '0) begin
                    state_next = ST_SKIP;
                end else begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_SKIP: begin
                if (top_digit == 4'd0 && dig_cnt_reg != '0) begin
                    bcd_next     = {bcd_reg[BCD_BITS-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN: begin
                if (load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = sitda_pkg::ASCII_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = sitda_pkg::digit_to_ascii(top_digit);
                    out_last_next  = (dig_cnt_reg == '0);
                    bcd_next       = {bcd_reg[BCD_BITS-5:0], 4'd0};
                    if (dig_cnt_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_character = out_char_reg;
    assign m_last      = out_last_reg;

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_char_reg == sitda_pkg::ASCII_MINUS) |-> !out_last_reg)
        else $error("minus sign flagged as last character");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_char_reg == sitda_pkg::ASCII_MINUS ||
                           (out_char_reg >= sitda_pkg::ASCII_ZERO &&
                            out_char_reg <= sitda_pkg::ASCII_NINE)))
        else $error("character outside sign and digit set");

    a_sign_then_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SIGN && load) |=>
        (state_reg == ST_DIGITS && out_valid_reg &&
         out_char_reg == sitda_pkg::ASCII_MINUS))
        else $error("sign not followed by digit emission");

    a_conv_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |=> (state_reg == ST_CONV || state_reg == ST_SKIP))
        else $error("conversion left early");

endmodule

`default_nettype wire
